// ----- hw/rtl/ymbs_pkg.sv -----
// Shared types and constants for the YMODEM batch sender.
// Phase, action, timer and operation codes, protocol bytes and field widths.
// No dependencies.
package ymbs_pkg;

    // Field and counter widths
    localparam int LENGTH_BITS = 24;
    localparam int BLOCK_BYTES = 128;
    localparam int BLK_W       = 18;
    localparam int OFF_W       = BLK_W + $clog2(BLOCK_BYTES);
    localparam int CNT_W       = $clog2(BLOCK_BYTES + 1);
    localparam int BYTE_W      = 8;
    localparam int FILE_W      = 8;
    localparam int RETRY_W     = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 1'b1;
    localparam logic [FILE_W-1:0]    FILE_COUNT_RESET  = 8'd1;
    localparam logic [RETRY_W-1:0]   RETRY_LIMIT_RESET = 4'd10;

    // Receiver bytes
    localparam logic [BYTE_W-1:0] RX_ACK = 8'h06;
    localparam logic [BYTE_W-1:0] RX_NAK = 8'h15;
    localparam logic [BYTE_W-1:0] RX_CAN = 8'h18;
    localparam logic [BYTE_W-1:0] RX_C   = 8'h43;

    typedef enum logic [1:0] {
        OP_RX_BYTE = 2'd0,
        OP_TIMEOUT = 2'd1,
        OP_START   = 2'd2,
        OP_CANCEL  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ACT_NONE         = 3'd0,
        ACT_HEADER       = 3'd1,
        ACT_DATA         = 3'd2,
        ACT_EOT          = 3'd3,
        ACT_FINAL_HEADER = 3'd4,
        ACT_CANCEL       = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        TMR_LEAVE  = 2'd0,
        TMR_STOP   = 2'd1,
        TMR_NORMAL = 2'd2,
        TMR_TRIPLE = 2'd3
    } timer_t;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_WAIT_START = 4'd1,
        PH_HEADER    = 4'd2,
        PH_DATA      = 4'd3,
        PH_EOT       = 4'd4,
        PH_NEXT_FILE = 4'd5,
        PH_FINAL_REQ = 4'd6,
        PH_FINAL     = 4'd7,
        PH_DONE      = 4'd8,
        PH_ERROR     = 4'd9
    } phase_t;

endpackage

// ----- hw/rtl/ymodem_batch_sender.sv -----
// YMODEM batch sender control path: phase machine, retry count and block/file counters.
// Single module; depends on ymbs_pkg.
//
// One item per clock. Each accepted item (received byte, timeout tick, start or
// local cancel) is decoded by one level of next-state logic straight from the input
// ports and produces exactly one result item, captured in the result register in the
// same edge that updates the session state. s_ready is high whenever the result
// register is empty or being drained, so a new item is taken in every cycle while the
// downstream side keeps up; a stalled result holds s_ready low. The result tells the link
// what to send (header, 128-byte data block given as offset and length with 0x1A padding,
// EOT, closing empty header or two CANs), what the response timer must do, and the phase
// after the item. NAKs and timeouts share one retry counter; passing retry_limit cancels
// into the error phase. file_count and retry_limit are written through the cfg port; the
// user must do so only while the block is idle, which the block itself does not enforce.
module ymodem_batch_sender (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 cfg_wr_en,
    input  logic [ymbs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ymbs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // input items
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_operation,
    input  logic [ymbs_pkg::BYTE_W-1:0]          s_rx_byte,
    input  logic [ymbs_pkg::LENGTH_BITS-1:0]     s_file_length,
    // result items
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [2:0]                           m_action,
    output logic [ymbs_pkg::BYTE_W-1:0]          m_packet_number,
    output logic [ymbs_pkg::LENGTH_BITS-1:0]     m_data_offset,
    output logic [ymbs_pkg::BYTE_W-1:0]          m_data_length,
    output logic [ymbs_pkg::FILE_W-1:0]          m_file_number,
    output logic [ymbs_pkg::LENGTH_BITS-1:0]     m_current_file_length,
    output logic [1:0]                           m_timer_command,
    output logic [3:0]                           m_phase_out
);

    localparam int LEN_W = ymbs_pkg::LENGTH_BITS;
    localparam int BLK_W = ymbs_pkg::BLK_W;
    localparam int OFF_W = ymbs_pkg::OFF_W;
    localparam int CNT_W = ymbs_pkg::CNT_W;

    // Configuration registers
    logic [ymbs_pkg::FILE_W-1:0]  file_count_reg;
    logic [ymbs_pkg::RETRY_W-1:0] retry_limit_reg;

    // Session state
    ymbs_pkg::phase_t             phase_reg, phase_next;
    logic [ymbs_pkg::RETRY_W-1:0] retry_reg, retry_next;
    logic [BLK_W-1:0]             block_reg, block_next;
    logic [ymbs_pkg::FILE_W-1:0]  file_reg, file_next;
    logic [LEN_W-1:0]             loaded_reg, loaded_next;
    logic [LEN_W-1:0]             sent_reg, sent_next;
    logic                         cancel_reg, cancel_next;

    // Result register
    logic                         m_valid_reg;
    ymbs_pkg::action_t            action_reg, action_next;
    logic [ymbs_pkg::BYTE_W-1:0]  pkt_reg, pkt_next;
    logic [LEN_W-1:0]             doff_reg, doff_next;
    logic [ymbs_pkg::BYTE_W-1:0]  dlen_reg, dlen_next;
    ymbs_pkg::timer_t             timer_reg, timer_next;
    logic [ymbs_pkg::FILE_W-1:0]  file_out_reg;
    logic [LEN_W-1:0]             len_out_reg;
    ymbs_pkg::phase_t             phase_out_reg;

    // Decode helpers
    ymbs_pkg::op_t                op;
    logic                         accept;
    logic                         is_ack, is_nak, is_can, is_req;
    logic                         active, resendable, byte_ok;
    logic                         all_sent;
    logic                         retry_evt, retry_over, resend;
    logic                         emit_req, emit_eot;
    logic [BLK_W-1:0]             bc_emit, blk_idx;
    logic [OFF_W-1:0]             off, remain;
    logic [CNT_W-1:0]             nbytes;
    logic [ymbs_pkg::FILE_W-1:0]  file_inc;

    assign op      = ymbs_pkg::op_t'(s_operation);
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign is_ack = (s_rx_byte == ymbs_pkg::RX_ACK);
    assign is_nak = (s_rx_byte == ymbs_pkg::RX_NAK);
    assign is_can = (s_rx_byte == ymbs_pkg::RX_CAN);
    assign is_req = (s_rx_byte == ymbs_pkg::RX_C) || is_nak;

    assign active = (phase_reg >= ymbs_pkg::PH_WAIT_START) &&
                    (phase_reg <= ymbs_pkg::PH_FINAL);
    // phases in which a packet is outstanding and NAK/timeout means resend
    assign resendable = (phase_reg == ymbs_pkg::PH_HEADER) ||
                        (phase_reg == ymbs_pkg::PH_DATA)   ||
                        (phase_reg == ymbs_pkg::PH_EOT)    ||
                        (phase_reg == ymbs_pkg::PH_FINAL);
    assign byte_ok  = (op == ymbs_pkg::OP_RX_BYTE) && !cancel_reg;
    assign all_sent = (sent_reg >= loaded_reg);
    assign file_inc = file_reg + 1'b1;

    // Retry counting is shared by NAK and timeout
    assign retry_evt  = resendable && ((op == ymbs_pkg::OP_TIMEOUT) || (byte_ok && is_nak));
    assign retry_over = ({1'b0, retry_reg} + 1'b1) > {1'b0, retry_limit_reg};
    assign resend     = retry_evt && !retry_over;

    // Data block issue: first block after 'C' on the header, next block after
    // an ACK with data left, or the same block again on a resend.
    assign emit_req = (byte_ok && (phase_reg == ymbs_pkg::PH_HEADER) &&
                       (s_rx_byte == ymbs_pkg::RX_C)) ||
                      (byte_ok && (phase_reg == ymbs_pkg::PH_DATA) && is_ack && !all_sent) ||
                      (resend && (phase_reg == ymbs_pkg::PH_DATA));

    always_comb begin
        if (phase_reg == ymbs_pkg::PH_HEADER) begin
            bc_emit = BLK_W'(1);
        end else if (byte_ok && is_ack) begin
            bc_emit = block_reg + 1'b1;
        end else begin
            bc_emit = block_reg;
        end
    end

    assign blk_idx  = bc_emit - 1'b1;
    assign off      = OFF_W'(blk_idx) * OFF_W'(ymbs_pkg::BLOCK_BYTES);
    assign emit_eot = (off >= OFF_W'(loaded_reg));
    assign remain   = OFF_W'(loaded_reg) - off;
    assign nbytes   = (remain > OFF_W'(ymbs_pkg::BLOCK_BYTES)) ?
                      CNT_W'(ymbs_pkg::BLOCK_BYTES) : remain[CNT_W-1:0];

    // Next session state
    always_comb begin
        phase_next  = phase_reg;
        retry_next  = retry_reg;
        block_next  = block_reg;
        file_next   = file_reg;
        loaded_next = loaded_reg;
        sent_next   = sent_reg;
        cancel_next = cancel_reg;

        case (op)
            ymbs_pkg::OP_START: begin
                cancel_next = 1'b0;
                file_next   = '0;
                sent_next   = '0;
                retry_next  = '0;
                block_next  = '0;
                if (file_count_reg == '0) begin
                    phase_next = ymbs_pkg::PH_ERROR;
                end else begin
                    loaded_next = s_file_length;
                    phase_next  = ymbs_pkg::PH_WAIT_START;
                end
            end
            ymbs_pkg::OP_CANCEL: begin
                cancel_next = 1'b1;
                if (active) begin
                    phase_next = ymbs_pkg::PH_ERROR;
                end
            end
            ymbs_pkg::OP_TIMEOUT: begin
                // retries handled below
            end
            ymbs_pkg::OP_RX_BYTE: begin
                if (!cancel_reg) begin
                    case (phase_reg)
                        ymbs_pkg::PH_WAIT_START: begin
                            if (is_req) begin
                                retry_next = '0;
                                phase_next = ymbs_pkg::PH_HEADER;
                            end
                        end
                        ymbs_pkg::PH_HEADER: begin
                            if (is_ack) begin
                                retry_next = '0;
                                block_next = BLK_W'(1);
                            end else if (s_rx_byte == ymbs_pkg::RX_C) begin
                                retry_next = '0;
                                block_next = BLK_W'(1);
                                phase_next = ymbs_pkg::PH_DATA;
                            end else if (is_can) begin
                                phase_next = ymbs_pkg::PH_ERROR;
                            end
                        end
                        ymbs_pkg::PH_DATA: begin
                            if (is_ack) begin
                                retry_next = '0;
                                block_next = block_reg + 1'b1;
                                if (all_sent) begin
                                    phase_next = ymbs_pkg::PH_EOT;
                                end
                            end else if (is_can) begin
                                phase_next = ymbs_pkg::PH_ERROR;
                            end
                        end
                        ymbs_pkg::PH_EOT: begin
                            if (is_ack) begin
                                retry_next = '0;
                                file_next  = file_inc;
                                phase_next = (file_inc < file_count_reg) ?
                                             ymbs_pkg::PH_NEXT_FILE : ymbs_pkg::PH_FINAL_REQ;
                            end else if (is_can) begin
                                phase_next = ymbs_pkg::PH_ERROR;
                            end
                        end
                        ymbs_pkg::PH_NEXT_FILE: begin
                            if (is_req) begin
                                retry_next = '0;
                                if (file_reg >= file_count_reg) begin
                                    phase_next = ymbs_pkg::PH_ERROR;
                                end else begin
                                    loaded_next = s_file_length;
                                    sent_next   = '0;
                                    phase_next  = ymbs_pkg::PH_HEADER;
                                end
                            end
                        end
                        ymbs_pkg::PH_FINAL_REQ: begin
                            if (is_req) begin
                                retry_next = '0;
                                phase_next = ymbs_pkg::PH_FINAL;
                            end
                        end
                        ymbs_pkg::PH_FINAL: begin
                            if (is_ack) begin
                                phase_next = ymbs_pkg::PH_DONE;
                            end else if (is_can) begin
                                phase_next = ymbs_pkg::PH_ERROR;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        if (retry_evt) begin
            if (retry_over) begin
                phase_next = ymbs_pkg::PH_ERROR;
            end else begin
                retry_next = retry_reg + 1'b1;
            end
        end

        // block past end of file turns into EOT
        if (emit_req) begin
            if (emit_eot) begin
                phase_next = ymbs_pkg::PH_EOT;
                retry_next = '0;
            end else begin
                sent_next = LEN_W'(off + OFF_W'(nbytes));
            end
        end
    end

    // Result item
    always_comb begin
        action_next = ymbs_pkg::ACT_NONE;
        timer_next  = ymbs_pkg::TMR_LEAVE;
        pkt_next    = '0;
        doff_next   = '0;
        dlen_next   = '0;

        case (op)
            ymbs_pkg::OP_START: begin
                timer_next = (file_count_reg == '0) ? ymbs_pkg::TMR_STOP : ymbs_pkg::TMR_TRIPLE;
            end
            ymbs_pkg::OP_CANCEL: begin
                if (active) begin
                    action_next = ymbs_pkg::ACT_CANCEL;
                    timer_next  = ymbs_pkg::TMR_STOP;
                end
            end
            ymbs_pkg::OP_TIMEOUT: begin
                if (phase_reg == ymbs_pkg::PH_WAIT_START) begin
                    timer_next = ymbs_pkg::TMR_TRIPLE;
                end else if ((phase_reg == ymbs_pkg::PH_NEXT_FILE) ||
                             (phase_reg == ymbs_pkg::PH_FINAL_REQ)) begin
                    timer_next = ymbs_pkg::TMR_NORMAL;
                end
            end
            ymbs_pkg::OP_RX_BYTE: begin
                if (!cancel_reg) begin
                    case (phase_reg)
                        ymbs_pkg::PH_WAIT_START: begin
                            if (is_req) begin
                                action_next = ymbs_pkg::ACT_HEADER;
                                timer_next  = ymbs_pkg::TMR_NORMAL;
                            end
                        end
                        ymbs_pkg::PH_HEADER: begin
                            if (is_ack) begin
                                timer_next = ymbs_pkg::TMR_TRIPLE;
                            end else if (s_rx_byte == ymbs_pkg::RX_C) begin
                                timer_next = ymbs_pkg::TMR_NORMAL;
                            end else if (is_can) begin
                                timer_next = ymbs_pkg::TMR_STOP;
                            end
                        end
                        ymbs_pkg::PH_DATA: begin
                            if (is_ack) begin
                                timer_next = ymbs_pkg::TMR_NORMAL;
                                if (all_sent) begin
                                    action_next = ymbs_pkg::ACT_EOT;
                                end
                            end else if (is_can) begin
                                timer_next = ymbs_pkg::TMR_STOP;
                            end
                        end
                        ymbs_pkg::PH_EOT: begin
                            if (is_ack) begin
                                timer_next = ymbs_pkg::TMR_TRIPLE;
                            end else if (is_can) begin
                                timer_next = ymbs_pkg::TMR_STOP;
                            end
                        end
                        ymbs_pkg::PH_NEXT_FILE: begin
                            if (is_req) begin
                                if (file_reg >= file_count_reg) begin
                                    timer_next = ymbs_pkg::TMR_STOP;
                                end else begin
                                    action_next = ymbs_pkg::ACT_HEADER;
                                    timer_next  = ymbs_pkg::TMR_NORMAL;
                                end
                            end
                        end
                        ymbs_pkg::PH_FINAL_REQ: begin
                            if (is_req) begin
                                action_next = ymbs_pkg::ACT_FINAL_HEADER;
                                timer_next  = ymbs_pkg::TMR_NORMAL;
                            end
                        end
                        ymbs_pkg::PH_FINAL: begin
                            if (is_ack || is_can) begin
                                timer_next = ymbs_pkg::TMR_STOP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        if (retry_evt) begin
            if (retry_over) begin
                action_next = ymbs_pkg::ACT_CANCEL;
                timer_next  = ymbs_pkg::TMR_STOP;
            end else begin
                timer_next = ymbs_pkg::TMR_NORMAL;
                case (phase_reg)
                    ymbs_pkg::PH_HEADER: action_next = ymbs_pkg::ACT_HEADER;
                    ymbs_pkg::PH_EOT:    action_next = ymbs_pkg::ACT_EOT;
                    ymbs_pkg::PH_FINAL:  action_next = ymbs_pkg::ACT_FINAL_HEADER;
                    default:             action_next = ymbs_pkg::ACT_NONE;
                endcase
            end
        end

        if (emit_req) begin
            if (emit_eot) begin
                action_next = ymbs_pkg::ACT_EOT;
            end else begin
                action_next = ymbs_pkg::ACT_DATA;
                pkt_next    = bc_emit[ymbs_pkg::BYTE_W-1:0];
                doff_next   = off[LEN_W-1:0];
                dlen_next   = ymbs_pkg::BYTE_W'(nbytes);
            end
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_count_reg  <= ymbs_pkg::FILE_COUNT_RESET;
            retry_limit_reg <= ymbs_pkg::RETRY_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ymbs_pkg::CFG_FILE_COUNT:  file_count_reg  <= cfg_wdata[ymbs_pkg::FILE_W-1:0];
                ymbs_pkg::CFG_RETRY_LIMIT: retry_limit_reg <= cfg_wdata[ymbs_pkg::RETRY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Session state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= ymbs_pkg::PH_IDLE;
            retry_reg   <= '0;
            block_reg   <= '0;
            file_reg    <= '0;
            loaded_reg  <= '0;
            sent_reg    <= '0;
            cancel_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg  <= phase_next;
                retry_reg  <= retry_next;
                block_reg  <= block_next;
                file_reg   <= file_next;
                loaded_reg <= loaded_next;
                sent_reg   <= sent_next;
                cancel_reg <= cancel_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            action_reg    <= action_next;
            pkt_reg       <= pkt_next;
            doff_reg      <= doff_next;
            dlen_reg      <= dlen_next;
            timer_reg     <= timer_next;
            file_out_reg  <= file_next;
            len_out_reg   <= loaded_next;
            phase_out_reg <= phase_next;
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_action              = action_reg;
    assign m_packet_number       = pkt_reg;
    assign m_data_offset         = doff_reg;
    assign m_data_length         = dlen_reg;
    assign m_timer_command       = timer_reg;
    assign m_file_number         = file_out_reg;
    assign m_current_file_length = len_out_reg;
    assign m_phase_out           = phase_out_reg;

`ifndef ASSERT_OFF
    // two CANs always land in the error phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (action_next == ymbs_pkg::ACT_CANCEL)) |=>
        (phase_reg == ymbs_pkg::PH_ERROR))
        else $error("cancel issued without entering error phase");

    // a good start clears the session counters
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (op == ymbs_pkg::OP_START) && (file_count_reg != '0)) |=>
        ((phase_reg == ymbs_pkg::PH_WAIT_START) && (retry_reg == '0) &&
         (block_reg == '0) && (file_reg == '0) && (sent_reg == '0)))
        else $error("start did not reset the session");

    // progress never runs past the loaded file
    assert property (@(posedge aclk) disable iff (!aresetn)
        sent_reg <= loaded_reg)
        else $error("sent bytes exceed file length");

    // a data block is non-empty and lies inside the current file
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (action_reg == ymbs_pkg::ACT_DATA)) |->
        ((dlen_reg != '0) && ({1'b0, doff_reg} + (LEN_W + 1)'(dlen_reg) <=
                              {1'b0, len_out_reg})))
        else $error("data block outside file");
`endif

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for ymodem_batch_sender: directed session walk, then random
// sessions under several file_count/retry_limit settings with random idling on both sides.
// Depends on ymbs_pkg and the ymodem_batch_sender RTL.
module tb;
    import ymbs_pkg::*;

    // One result item of the block, field for field.
    typedef struct packed {
        action_t                  action;
        logic [BYTE_W-1:0]        packet_number;
        logic [LENGTH_BITS-1:0]   data_offset;
        logic [BYTE_W-1:0]        data_length;
        logic [FILE_W-1:0]        file_number;
        logic [LENGTH_BITS-1:0]   current_file_length;
        timer_t                   timer_command;
        phase_t                   phase_out;
    } sender_cmd_t;

    // Tracks the session the block should be in and checks every command it issues.
    class session_checker;
        logic [FILE_W-1:0]      file_count;
        logic [RETRY_W-1:0]     retry_limit;
        phase_t                 phase;
        logic [RETRY_W-1:0]     retry_count;
        logic [BLK_W-1:0]       block_counter;
        logic [FILE_W-1:0]      file_counter;
        logic [LENGTH_BITS-1:0] loaded_length;
        logic [LENGTH_BITS-1:0] sent_bytes;
        bit                     cancelled;
        sender_cmd_t            cmd;
        sender_cmd_t            expected_commands[$];
        int                     failures;
        int                     checked;

        function new();
            file_count    = FILE_COUNT_RESET;
            retry_limit   = RETRY_LIMIT_RESET;
            phase         = PH_IDLE;
            retry_count   = '0;
            block_counter = '0;
            file_counter  = '0;
            loaded_length = '0;
            sent_bytes    = '0;
            cancelled     = 1'b0;
            failures      = 0;
            checked       = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_FILE_COUNT) begin
                file_count = value[FILE_W-1:0];
            end else if (idx == CFG_RETRY_LIMIT) begin
                retry_limit = value[RETRY_W-1:0];
            end
        endfunction

        // Data block for the current block number, or EOT once the file is used up.
        function void issue_data_block();
            logic [BLK_W-1:0] prior_block;
            longint unsigned  offset;
            longint unsigned  count;
            prior_block = block_counter - 1'b1;
            offset = longint'(prior_block) * BLOCK_BYTES;
            if (offset >= loaded_length) begin
                phase       = PH_EOT;
                retry_count = '0;
                cmd.action  = ACT_EOT;
                return;
            end
            count = loaded_length - offset;
            if (count > BLOCK_BYTES) count = BLOCK_BYTES;
            cmd.action        = ACT_DATA;
            cmd.packet_number = block_counter[7:0];
            cmd.data_offset   = offset[LENGTH_BITS-1:0];
            cmd.data_length   = count[7:0];
            sent_bytes        = LENGTH_BITS'(offset + count);
        endfunction

        // Returns 1 when the retry budget is blown and the session is cancelled.
        function bit count_retry();
            logic [RETRY_W:0] next_count;
            next_count = retry_count + 1'b1;
            if (next_count > retry_limit) begin
                cmd.action        = ACT_CANCEL;
                cmd.timer_command = TMR_STOP;
                phase             = PH_ERROR;
                return 1'b1;
            end
            retry_count = next_count[RETRY_W-1:0];
            return 1'b0;
        endfunction

        function void repeat_packet();
            case (phase)
                PH_HEADER: cmd.action = ACT_HEADER;
                PH_DATA:   issue_data_block();
                PH_EOT:    cmd.action = ACT_EOT;
                PH_FINAL:  cmd.action = ACT_FINAL_HEADER;
                default: ;
            endcase
            cmd.timer_command = TMR_NORMAL;
        endfunction

        function void enter_error();
            phase             = PH_ERROR;
            cmd.timer_command = TMR_STOP;
        endfunction

        function void on_rx_byte(input logic [BYTE_W-1:0] rx);
            bit request;
            request = (rx == RX_C) || (rx == RX_NAK);
            case (phase)
                PH_WAIT_START: begin
                    if (request) begin
                        retry_count       = '0;
                        phase             = PH_HEADER;
                        cmd.action        = ACT_HEADER;
                        cmd.timer_command = TMR_NORMAL;
                    end
                end
                PH_HEADER: begin
                    if (rx == RX_ACK) begin
                        retry_count       = '0;
                        block_counter     = BLK_W'(1);
                        cmd.timer_command = TMR_TRIPLE;
                    end else if (rx == RX_C) begin
                        retry_count   = '0;
                        phase         = PH_DATA;
                        block_counter = BLK_W'(1);
                        issue_data_block();
                        cmd.timer_command = TMR_NORMAL;
                    end else if (rx == RX_NAK) begin
                        if (!count_retry()) repeat_packet();
                    end else if (rx == RX_CAN) begin
                        enter_error();
                    end
                end
                PH_DATA: begin
                    if (rx == RX_ACK) begin
                        retry_count   = '0;
                        block_counter = block_counter + 1'b1;
                        if (sent_bytes >= loaded_length) begin
                            phase      = PH_EOT;
                            cmd.action = ACT_EOT;
                        end else begin
                            issue_data_block();
                        end
                        cmd.timer_command = TMR_NORMAL;
                    end else if (rx == RX_NAK) begin
                        if (!count_retry()) repeat_packet();
                    end else if (rx == RX_CAN) begin
                        enter_error();
                    end
                end
                PH_EOT: begin
                    if (rx == RX_ACK) begin
                        retry_count       = '0;
                        file_counter      = file_counter + 1'b1;
                        phase             = (file_counter < file_count) ? PH_NEXT_FILE
                                                                        : PH_FINAL_REQ;
                        cmd.timer_command = TMR_TRIPLE;
                    end else if (rx == RX_NAK) begin
                        if (!count_retry()) repeat_packet();
                    end else if (rx == RX_CAN) begin
                        enter_error();
                    end
                end
                PH_NEXT_FILE: begin
                    if (request) begin
                        retry_count = '0;
                        if (file_counter >= file_count) begin
                            enter_error();
                        end else begin
                            sent_bytes        = '0;
                            phase             = PH_HEADER;
                            cmd.action        = ACT_HEADER;
                            cmd.timer_command = TMR_NORMAL;
                        end
                    end
                end
                PH_FINAL_REQ: begin
                    if (request) begin
                        retry_count       = '0;
                        phase             = PH_FINAL;
                        cmd.action        = ACT_FINAL_HEADER;
                        cmd.timer_command = TMR_NORMAL;
                    end
                end
                PH_FINAL: begin
                    if (rx == RX_ACK) begin
                        phase             = PH_DONE;
                        cmd.timer_command = TMR_STOP;
                    end else if (rx == RX_NAK) begin
                        if (!count_retry()) repeat_packet();
                    end else if (rx == RX_CAN) begin
                        enter_error();
                    end
                end
                default: ;
            endcase
        endfunction

        // Called at the edge that accepts an input item; queues the command it must cause.
        function void note_item(input op_t op, input logic [BYTE_W-1:0] rx,
                                input logic [LENGTH_BITS-1:0] flen);
            bit active;
            active = (phase >= PH_WAIT_START) && (phase <= PH_FINAL);
            cmd = '0;
            case (op)
                OP_START: begin
                    cancelled     = 1'b0;
                    file_counter  = '0;
                    sent_bytes    = '0;
                    retry_count   = '0;
                    block_counter = '0;
                    if (file_count == 0) begin
                        enter_error();
                    end else begin
                        loaded_length     = flen;
                        phase             = PH_WAIT_START;
                        cmd.timer_command = TMR_TRIPLE;
                    end
                end
                OP_CANCEL: begin
                    cancelled = 1'b1;
                    if (active) begin
                        cmd.action = ACT_CANCEL;
                        enter_error();
                    end
                end
                OP_TIMEOUT: begin
                    if (phase == PH_WAIT_START) begin
                        cmd.timer_command = TMR_TRIPLE;
                    end else if (phase == PH_NEXT_FILE || phase == PH_FINAL_REQ) begin
                        cmd.timer_command = TMR_NORMAL;
                    end else if (active) begin
                        if (!count_retry()) repeat_packet();
                    end
                end
                default: begin
                    if (!cancelled) begin
                        // next file's length is latched on its request
                        if (phase == PH_NEXT_FILE && (rx == RX_C || rx == RX_NAK)
                                && file_counter < file_count) begin
                            loaded_length = flen;
                        end
                        on_rx_byte(rx);
                    end
                end
            endcase
            cmd.file_number         = file_counter;
            cmd.current_file_length = loaded_length;
            cmd.phase_out           = phase;
            expected_commands.push_back(cmd);
        endfunction

        function string describe(input sender_cmd_t c);
            return $sformatf("act=%0d pkt=%0d off=%0d len=%0d file=%0d flen=%0d tmr=%0d ph=%0d",
                             c.action, c.packet_number, c.data_offset, c.data_length,
                             c.file_number, c.current_file_length, c.timer_command,
                             c.phase_out);
        endfunction

        function void note_failure(input string msg);
            failures++;
            if (failures <= 10) $display("MISMATCH: %s", msg);
        endfunction

        function void check_result(input sender_cmd_t got);
            sender_cmd_t want;
            if (expected_commands.size() == 0) begin
                note_failure({"unexpected result ", describe(got)});
                return;
            end
            want = expected_commands.pop_front();
            checked++;
            if (got.action !== want.action
                    || got.packet_number !== want.packet_number
                    || got.data_offset !== want.data_offset
                    || got.data_length !== want.data_length
                    || got.file_number !== want.file_number
                    || got.current_file_length !== want.current_file_length
                    || got.timer_command !== want.timer_command
                    || got.phase_out !== want.phase_out) begin
                note_failure($sformatf("result %0d expected %s got %s", checked,
                                       describe(want), describe(got)));
            end
        endfunction

        function void close_out();
            if (expected_commands.size() != 0) begin
                note_failure($sformatf("%0d results never arrived",
                                       expected_commands.size()));
            end
        endfunction
    endclass

    // ---------------------------------------------------------------------------------
    // DUT hookup. Every input starts at a known value.
    // ---------------------------------------------------------------------------------
    logic                    aclk          = 1'b0;
    logic                    aresetn       = 1'b0;
    logic                    cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index     = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata     = '0;
    logic                    s_valid       = 1'b0;
    logic                    s_ready;
    logic [1:0]              s_operation   = '0;
    logic [BYTE_W-1:0]       s_rx_byte     = '0;
    logic [LENGTH_BITS-1:0]  s_file_length = '0;
    logic                    m_valid;
    logic                    m_ready       = 1'b0;
    logic [2:0]              m_action;
    logic [BYTE_W-1:0]       m_packet_number;
    logic [LENGTH_BITS-1:0]  m_data_offset;
    logic [BYTE_W-1:0]       m_data_length;
    logic [FILE_W-1:0]       m_file_number;
    logic [LENGTH_BITS-1:0]  m_current_file_length;
    logic [1:0]              m_timer_command;
    logic [3:0]              m_phase_out;

    // When set, neither side inserts idle cycles.
    bit calm = 1'b0;

    session_checker session_check = new();

    ymodem_batch_sender u_top (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_wr_en             (cfg_wr_en),
        .cfg_index             (cfg_index),
        .cfg_wdata             (cfg_wdata),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_operation           (s_operation),
        .s_rx_byte             (s_rx_byte),
        .s_file_length         (s_file_length),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_action              (m_action),
        .m_packet_number       (m_packet_number),
        .m_data_offset         (m_data_offset),
        .m_data_length         (m_data_length),
        .m_file_number         (m_file_number),
        .m_current_file_length (m_current_file_length),
        .m_timer_command       (m_timer_command),
        .m_phase_out           (m_phase_out)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hard stop in case the block hangs a handshake.
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ---------------------------------------------------------------------------------
    // Result side. Signals are sampled right after the edge, i.e. the values that the
    // edge itself saw. m_ready drops at random about 11% of the time; once, after a few
    // hundred results, it stays low for a long stretch so the result register fills and
    // s_ready backs up against the sender.
    // ---------------------------------------------------------------------------------
    initial begin : result_sink
        int          hold_cycles;
        bit          held;
        sender_cmd_t got;
        hold_cycles = 0;
        held        = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.action              = action_t'(m_action);
                got.packet_number       = m_packet_number;
                got.data_offset         = m_data_offset;
                got.data_length         = m_data_length;
                got.file_number         = m_file_number;
                got.current_file_length = m_current_file_length;
                got.timer_command       = timer_t'(m_timer_command);
                got.phase_out           = phase_t'(m_phase_out);
                session_check.check_result(got);
            end
            if (!held && session_check.checked >= 300) begin
                held        = 1'b1;
                hold_cycles = 200;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(0, 99) >= 11);
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------------------------

    // Offers one item and returns at the edge that takes it. Valid stays up across
    // back-to-back items; it only drops for a random idle gap.
    task automatic send_item(input op_t op, input logic [BYTE_W-1:0] rx,
                             input logic [LENGTH_BITS-1:0] flen);
        if (!calm && $urandom_range(0, 99) < 11) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 11);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_rx_byte     <= rx;
        s_file_length <= flen;
        do @(posedge aclk); while (!s_ready);
        session_check.note_item(op, rx, flen);
    endtask

    // Stop offering and wait until every queued command has come back.
    task automatic drain();
        s_valid <= 1'b0;
        while (session_check.expected_commands.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // Both registers, back to back. Upper bits of the retry word are junk the block
    // must drop.
    task automatic load_settings(input logic [FILE_W-1:0] files,
                                 input logic [RETRY_W-1:0] retries);
        logic [CFG_DATA_W-1:0] retry_word;
        retry_word = CFG_DATA_W'($urandom);
        retry_word[RETRY_W-1:0] = retries;
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_FILE_COUNT;
        cfg_wdata <= files;
        @(posedge aclk);
        session_check.write_reg(CFG_FILE_COUNT, files);
        cfg_index <= CFG_RETRY_LIMIT;
        cfg_wdata <= retry_word;
        @(posedge aclk);
        session_check.write_reg(CFG_RETRY_LIMIT, retry_word);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly short files so whole sessions finish; some exact block multiples, some
    // empty, some full-width (those get aborted part way).
    function automatic logic [LENGTH_BITS-1:0] pick_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return '0;
        if (roll < 75) return LENGTH_BITS'($urandom_range(1, 700));
        if (roll < 85) return LENGTH_BITS'($urandom_range(1, 4) * BLOCK_BYTES);
        return LENGTH_BITS'($urandom);
    endfunction

    // One item of a random session: usually the reply a well-behaved receiver would
    // give in the current phase, otherwise NAKs, timeouts, CANs, junk bytes, local
    // cancels or restarts.
    task automatic send_session_item();
        op_t                    op;
        logic [BYTE_W-1:0]      rx;
        logic [LENGTH_BITS-1:0] flen;
        int                     dice;
        op   = OP_RX_BYTE;
        rx   = BYTE_W'($urandom);
        flen = LENGTH_BITS'($urandom);
        dice = $urandom_range(0, 99);
        if (session_check.phase == PH_DATA && session_check.loaded_length > 4096
                && session_check.block_counter > 6 && dice < 25) begin
            // big file: cut it short rather than stream thousands of blocks
            op = (dice < 12) ? OP_START : OP_CANCEL;
        end else if (dice < 88) begin
            case (session_check.phase)
                PH_IDLE, PH_DONE, PH_ERROR: begin
                    if ($urandom_range(0, 9) < 7) op = OP_START;
                end
                PH_WAIT_START, PH_NEXT_FILE, PH_FINAL_REQ: begin
                    rx = ($urandom_range(0, 7) == 0) ? RX_NAK : RX_C;
                end
                PH_HEADER: begin
                    rx = $urandom_range(0, 1) ? RX_ACK : RX_C;
                end
                default: begin
                    rx = RX_ACK;
                end
            endcase
            // a retry already under way tends to turn into a run of them
            if (session_check.retry_count != 0 && $urandom_range(0, 1)) begin
                if ($urandom_range(0, 1)) begin
                    op = OP_TIMEOUT;
                end else begin
                    op = OP_RX_BYTE;
                    rx = RX_NAK;
                end
            end
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2: rx = RX_NAK;
                3, 4:    op = OP_TIMEOUT;
                5:       rx = RX_CAN;
                6:       ;
                7:       op = OP_CANCEL;
                8:       op = OP_START;
                default: rx = RX_ACK;
            endcase
        end
        if (op == OP_START || session_check.phase == PH_NEXT_FILE) flen = pick_length();
        send_item(op, rx, flen);
    endtask

    // Settings per random phase: file counts from zero to the largest, retry limits from one to the largest.
    int plan_files   [8] = '{3,   255, 2,   0,  1,   4,   1,   7};
    int plan_retries [8] = '{1,   15,  2,   5,  15,  3,   1,   10};
    int plan_items   [8] = '{150, 160, 150, 12, 160, 160, 130, 150};

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed walk with reset settings (one file, ten retries).
        send_item(OP_RX_BYTE, RX_C,    24'd0);        // byte while idle: ignored
        send_item(OP_TIMEOUT, 8'h00,   24'd0);        // timeout while idle: ignored
        send_item(OP_CANCEL,  8'h00,   24'd0);        // cancel while idle: flag only
        send_item(OP_RX_BYTE, RX_C,    24'd0);        // flagged: byte dropped
        send_item(OP_START,   8'hFF,   24'hFFFFFF);   // largest file
        send_item(OP_TIMEOUT, 8'h00,   24'd0);        // still waiting: triple timer
        send_item(OP_RX_BYTE, 8'hFF,   24'd0);        // unknown byte: ignored
        send_item(OP_RX_BYTE, RX_NAK,  24'd0);        // NAK also asks for header
        send_item(OP_RX_BYTE, RX_ACK,  24'd0);        // header acked
        send_item(OP_RX_BYTE, RX_C,    24'd0);        // first data block
        send_item(OP_RX_BYTE, RX_ACK,  24'd0);        // second block
        send_item(OP_RX_BYTE, RX_NAK,  24'd0);        // resend on NAK
        send_item(OP_TIMEOUT, 8'h00,   24'd0);        // resend on timeout
        send_item(OP_RX_BYTE, RX_CAN,  24'd0);        // receiver cancels: error
        send_item(OP_START,   8'h00,   24'd0);        // empty file
        send_item(OP_RX_BYTE, RX_C,    24'd0);
        send_item(OP_RX_BYTE, RX_C,    24'd0);        // nothing to send: straight to EOT
        send_item(OP_RX_BYTE, RX_ACK,  24'd0);        // last file done: wait final 'C'
        send_item(OP_TIMEOUT, 8'h00,   24'd0);
        send_item(OP_RX_BYTE, RX_C,    24'd0);        // closing empty header
        send_item(OP_RX_BYTE, RX_NAK,  24'd0);
        send_item(OP_RX_BYTE, RX_ACK,  24'd0);        // done
        send_item(OP_START,   8'h00,   24'd200);      // one full block plus a short one
        send_item(OP_RX_BYTE, RX_C,    24'd0);
        send_item(OP_RX_BYTE, RX_C,    24'd0);
        send_item(OP_RX_BYTE, RX_ACK,  24'd0);        // 72-byte tail block
        send_item(OP_RX_BYTE, RX_ACK,  24'd0);        // all sent: EOT
        send_item(OP_CANCEL,  8'h00,   24'd0);        // local cancel mid-session: two CANs

        for (int p = 0; p < 8; p++) begin
            // block is quiet here: every command back before the registers move
            drain();
            load_settings(FILE_W'(plan_files[p]), RETRY_W'(plan_retries[p]));
            calm <= (p == 4);
            for (int k = 0; k < plan_items[p]; k++) send_session_item();
            if (p == 1) begin
                // Park between files with at least two done, so the smaller file count
                // of the next phase makes the next file request run past the batch.
                for (int k = 0; k < 400 && !(session_check.phase == PH_NEXT_FILE
                        && session_check.file_counter >= plan_files[2]); k++) begin
                    send_session_item();
                end
            end
        end
        drain();

        session_check.close_out();
        if (session_check.failures == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/ymbs_pkg.sv
hw/rtl/ymodem_batch_sender.sv
tb/sv/tb.sv
